// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; expects signals clk and rst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define MRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is held
`define MRT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mrt_pkg.sv =====
// shared widths, defaults and register codes for the moving rms threshold block
// no dependencies
package mrt_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 16;
    localparam int THR_W      = 16;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // defaults for the top level parameters
    localparam int WINDOW_DEFAULT      = 10;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // threshold register reset value
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd5000;

    // register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

endpackage

// ===== src/moving_rms_threshold.sv =====
// Moving-window RMS of a light sensor with a low-light flag.
// Input: one 16-bit unsigned sample word per s_axis transfer (tvalid and tready high).
// Output: one word per input on m_axis: tdata is the RMS value, tuser the flag that
// is set when the RMS is strictly below the threshold register.
// Each sample is squared and divided by WINDOW (bit-serial), the quotient replaces
// the oldest ring entry, and the floor square root of the ring sum is produced
// one bit per cycle.
// The serial square, divide and root units work on each sample in turn. One sample
// is in work at a time: a new sample is taken only after the result of the last one
// has moved into the output register, which waits while the output is drained.
// A finished word waits in the output register; the next sample is accepted
// meanwhile, and the block holds its result until the receiver takes the old word.
// Reset clears the ring (through per-entry valid bits), the sum, the write slot
// and the output valid bit, and loads the threshold with 5000. The threshold is
// at APB address 0 and should be written only while no sample is in work.
// Depends on mrt_pkg, mrt_ram, mrt_sqdiv and mrt_isqrt.
module moving_rms_threshold #(
    parameter int WINDOW      = mrt_pkg::WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = mrt_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mrt_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] light_sample
    // result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mrt_pkg::RMS_W-1:0]       m_axis_tdata,   // [15:0] rms_value
    output logic                            m_axis_tuser,   // [0] below_threshold
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mrt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mrt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import mrt_pkg::*;

    localparam int SW     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SUM_W  = 2 * SW;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CALC = 6'b000010,
        ST_SUB  = 6'b000100,
        ST_ADD  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]  rms_reg, rms_next;
    logic              below_reg, below_next;

    logic              in_accept;
    logic              cfg_write;
    logic              sq_done;
    logic [SUM_W-1:0]  entry;
    logic [SUM_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]  old_entry;
    logic [SUM_W-1:0]  sum_add;
    logic              ring_we;
    logic              rt_start;
    logic              rt_done;
    logic [SW-1:0]     root;
    logic [RMS_W-1:0]  root_ext;
    logic              out_load;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // square and divide by the window size
    mrt_sqdiv #(
        .SW     (SW),
        .WINDOW (WINDOW)
    ) u_sqdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .sample (s_axis_tdata[SW-1:0]),
        .done   (sq_done),
        .entry  (entry)
    );

    // ring of the most recent quotients
    mrt_ram #(
        .WIDTH (SUM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (entry),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // entries never written count as zero
    assign old_entry = valid_reg[slot_reg] ? ram_rdata : '0;
    assign sum_add   = sum_reg + entry;
    assign ring_we   = (state_reg == ST_ADD);
    assign rt_start  = (state_reg == ST_ADD);

    // floor square root of the updated sum
    mrt_isqrt #(
        .RT_W (SW)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_start),
        .value (sum_add),
        .done  (rt_done),
        .root  (root)
    );

    assign root_ext = RMS_W'(root);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // item sequencer and ring bookkeeping
    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        slot_next  = slot_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (sq_done)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                sum_next   = sum_reg - old_entry;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                sum_next             = sum_add;
                valid_next[slot_reg] = 1'b1;
                slot_next            = (slot_reg == SLOT_W'(WINDOW - 1)) ?
                                       '0 : slot_reg + 1'b1;
                state_next           = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rms_next   = rms_reg;
        below_next = below_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            rms_next       = root_ext;
            below_next     = (root_ext < thr_reg);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // threshold register write
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_write && (paddr[2] == REG_THRESHOLD))
        begin
            thr_next = pwdata[THR_W-1:0];
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            slot_reg      <= '0;
            valid_reg     <= '0;
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            valid_reg     <= valid_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rms_reg   <= rms_next;
        below_reg <= below_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rms_reg;
    assign m_axis_tuser  = below_reg;

    // register read back
    assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DATA_W'(thr_reg) : '0;
    assign pready = 1'b1;

endmodule

// ===== src/mrt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module mrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mrt_sqdiv.sv =====
// bit-serial square of a sample followed by bit-serial division by the window size
// uses mrt_pkg; one product bit per cycle, then one quotient bit per cycle
module mrt_sqdiv #(
    parameter int SW     = 16,
    parameter int WINDOW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SW-1:0]   sample,
    output logic            done,
    output logic [2*SW-1:0] entry
);
    import mrt_pkg::*;

    localparam int SQ_W  = 2 * SW;
    localparam int REM_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(SQ_W);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_DONE = 4'b1000
    } ustate_t;

    ustate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]  prod_reg, prod_next;
    logic [SW-1:0]    mcand_reg, mcand_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    logic [SW:0]      mul_sum;
    logic [REM_W:0]   trial;
    logic             ge;

    // shift-add step: add multiplicand into the high half when the low bit is set
    assign mul_sum = {1'b0, prod_reg[SQ_W-1:SW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    // restoring division step by the constant window size
    assign trial = {rem_reg, prod_reg[SQ_W-1]};
    assign ge    = (trial >= (REM_W+1)'(WINDOW));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    prod_next  = {{SW{1'b0}}, sample};
                    mcand_next = sample;
                    cnt_next   = CNT_W'(SW - 1);
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                prod_next = {mul_sum, prod_reg[SW-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(SQ_W - 1);
                    rem_next   = '0;
                    state_next = U_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_DIV:
            begin
                prod_next = {prod_reg[SQ_W-2:0], ge};
                rem_next  = ge ? REM_W'(trial - (REM_W+1)'(WINDOW)) : trial[REM_W-1:0];
                if (cnt_reg == '0)
                begin
                    state_next = U_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        rem_reg   <= rem_next;
    end

    assign done  = (state_reg == U_DONE);
    assign entry = prod_reg;

endmodule

// ===== src/mrt_isqrt.sv =====
// bit-serial floor square root, one root bit per cycle from two operand bits
// uses mrt_pkg; operand width must be even
module mrt_isqrt #(
    parameter int RT_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2*RT_W-1:0] value,
    output logic              done,
    output logic [RT_W-1:0]   root
);
    import mrt_pkg::*;

    localparam int VAL_W = 2 * RT_W;
    localparam int CNT_W = $clog2(RT_W);

    typedef enum logic [2:0] {
        Q_IDLE = 3'b001,
        Q_RUN  = 3'b010,
        Q_DONE = 3'b100
    } qstate_t;

    qstate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [RT_W-1:0]  rem_reg, rem_next;
    logic [RT_W-1:0]  root_reg, root_next;

    logic [RT_W+1:0]  rem_sh;
    logic [RT_W+1:0]  trial;
    logic [RT_W+1:0]  rem_diff;
    logic             ge;

    // bring down the next bit pair and try root*4+1
    assign rem_sh   = {rem_reg, val_reg[VAL_W-1:VAL_W-2]};
    assign trial    = {root_reg, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    val_next   = value;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(RT_W - 1);
                    state_next = Q_RUN;
                end
            end
            Q_RUN:
            begin
                val_next  = {val_reg[VAL_W-3:0], 2'b00};
                rem_next  = ge ? rem_diff[RT_W-1:0] : rem_sh[RT_W-1:0];
                root_next = {root_reg[RT_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    state_next = Q_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            Q_DONE:
            begin
                state_next = Q_IDLE;
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = (state_reg == Q_DONE);
    assign root = root_reg;

endmodule

// ===== src/mrt_checker.sv =====
// port-level checks for moving_rms_threshold, bound to the top level
// uses mrt_pkg and assert_macros.svh
`include "assert_macros.svh"

module mrt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [mrt_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] light_sample
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mrt_pkg::RMS_W-1:0]       m_axis_tdata,   // [15:0] rms_value
    input logic                            m_axis_tuser,   // [0] below_threshold
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [mrt_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [mrt_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [mrt_pkg::APB_DATA_W-1:0]  prdata,
    input logic                            pready
);
    import mrt_pkg::*;

    // a clock edge in reset leaves no result pending and the input open
    `MRT_ASSERT_RST(a_reset_clear, (!rst_n |=> (!m_axis_tvalid && s_axis_tready)), "output not clear after reset")

    // a stalled result word holds
    `MRT_ASSERT(a_out_hold, ((m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))), "stalled result word changed")

    // one sample in work at a time
    `MRT_ASSERT(a_one_in_work, ((s_axis_tvalid && s_axis_tready) |=> !s_axis_tready), "input taken while a sample is in work")

    // flag agrees with the value and the threshold read back
    `MRT_ASSERT(a_flag_match, ((m_axis_tvalid && (paddr[2] == REG_THRESHOLD)) |-> (m_axis_tuser == (m_axis_tdata < prdata[THR_W-1:0]))), "flag disagrees with threshold")

    // configuration port never stalls
    `MRT_ASSERT(a_pready, (psel |-> pready), "configuration port stalled")

endmodule

bind moving_rms_threshold mrt_checker u_mrt_checker (.*);
